[design/orl_pkg.sv]
package orl_pkg;

  localparam int CHAR_W      = 8;
  localparam int ADDR_W      = 24;
  localparam int BYTE_W      = 8;
  localparam int KIND_W      = 2;
  localparam int NAME_W      = 48;
  localparam int POS_W       = 4;

  // Hex digits of the load address in T and E records
  localparam int ADDR_DIGITS = 6;
  localparam logic [POS_W-1:0] ADDR_FIRST_POS = POS_W'(2);
  localparam logic [POS_W-1:0] ADDR_LAST_POS  = POS_W'(1 + ADDR_DIGITS);
  localparam logic [POS_W-1:0] DATA_START     = POS_W'(12);
  localparam logic [POS_W-1:0] POS_MAX        = POS_W'(15);
  localparam logic [POS_W-1:0] NAME_LAST_POS  = POS_W'(7);
  localparam logic [POS_W-1:0] HEADER_MIN_LEN = POS_W'(8);

  // Event codes
  localparam logic [KIND_W-1:0] EV_STORE    = 2'd0;
  localparam logic [KIND_W-1:0] EV_JUMP     = 2'd1;
  localparam logic [KIND_W-1:0] EV_MISMATCH = 2'd2;

  // Record kinds
  localparam logic [1:0] REC_OTHER = 2'd0;
  localparam logic [1:0] REC_T     = 2'd1;
  localparam logic [1:0] REC_E     = 2'd2;

  // Run phases; bit 1 set means halted
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_LOAD   = 2'd1;
  localparam logic [1:0] PH_HALT   = 2'd2;

  localparam logic [CHAR_W-1:0] CH_T      = 8'h54;
  localparam logic [CHAR_W-1:0] CH_E      = 8'h45;
  localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [CHAR_W-1:0] CH_CARET  = 8'h5E;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;

  function automatic logic [3:0] hex_value(input logic [CHAR_W-1:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      v = 4'(c[3:0] + 4'd9);
    end
    return v;
  endfunction

  function automatic logic is_blank(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || (c inside {[8'd9:8'd13]});
  endfunction

endpackage

[design/orl_char_if.sv]
interface orl_char_if
  import orl_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

[design/orl_event_if.sv]
interface orl_event_if
  import orl_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] event_kind;
  logic [ADDR_W-1:0] load_address;
  logic [BYTE_W-1:0] load_byte;

  modport source (output valid, output event_kind, output load_address, output load_byte,
                  input ready);
  modport sink   (input valid, input event_kind, input load_address, input load_byte,
                  output ready);
endinterface

[design/object_record_loader_top.sv]
// An item taken into the input register gives its event (if any) through the event register.
// Throughput: one item per cycle while events are taken; one input register and one event register,
// the record decode sits between them.
// Input stalls only while the event register is full and not taken.
// Reset (rst, synchronous) clears the parse state, the name register and both
// valid bits; the block then expects the header record.
module object_record_loader_top
  import orl_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [NAME_W-1:0] cfg_wr_data,
  orl_char_if.sink          chars,
  orl_event_if.source       events
);

  logic [NAME_W-1:0] expected_name;

  logic              in_valid;
  logic [CHAR_W-1:0] in_char;

  logic [1:0]        run_phase, run_phase_next;
  logic [1:0]        record_kind, record_kind_next;
  logic [POS_W-1:0]  char_position, char_position_next;
  logic [ADDR_W-1:0] current_address, current_address_next;
  logic              name_differs, name_differs_next;
  logic [3:0]        high_nibble, high_nibble_next;
  logic              nibble_pending, nibble_pending_next;
  logic              data_ended, data_ended_next;

  logic              emit;
  logic [KIND_W-1:0] emit_kind;
  logic [ADDR_W-1:0] emit_addr;
  logic [BYTE_W-1:0] emit_byte;

  logic              out_valid;
  logic [KIND_W-1:0] out_kind;
  logic [ADDR_W-1:0] out_addr;
  logic [BYTE_W-1:0] out_byte;

  logic              advance;
  logic [3:0]        digit;
  logic [2:0]        name_sel;
  logic [CHAR_W-1:0] name_char;

  assign advance     = in_valid && (!out_valid || events.ready);
  assign chars.ready = !in_valid || advance;

  assign digit     = hex_value(in_char);
  assign name_sel  = 3'(NAME_LAST_POS - char_position);
  assign name_char = expected_name[name_sel*8 +: 8];

  always_comb begin
    run_phase_next       = run_phase;
    record_kind_next     = record_kind;
    char_position_next   = char_position;
    current_address_next = current_address;
    name_differs_next    = name_differs;
    high_nibble_next     = high_nibble;
    nibble_pending_next  = nibble_pending;
    data_ended_next      = data_ended;
    emit                 = 1'b0;
    emit_kind            = EV_STORE;
    emit_addr            = '0;
    emit_byte            = '0;

    if (run_phase[1]) begin
      // halted: everything ignored
    end else if (is_blank(in_char)) begin
      if (char_position != '0) begin
        char_position_next  = '0;
        record_kind_next    = REC_OTHER;
        nibble_pending_next = 1'b0;
        data_ended_next     = 1'b0;
        if (run_phase == PH_HEADER) begin
          if (name_differs || char_position < HEADER_MIN_LEN) begin
            name_differs_next = 1'b1;
            run_phase_next    = PH_HALT;
            emit              = 1'b1;
            emit_kind         = EV_MISMATCH;
          end else begin
            run_phase_next = PH_LOAD;
          end
        end else if (record_kind == REC_E) begin
          run_phase_next = PH_HALT;
          emit           = 1'b1;
          emit_kind      = EV_JUMP;
          emit_addr      = current_address;
        end
      end
    end else begin
      if (char_position < POS_MAX) begin
        char_position_next = char_position + POS_W'(1);
      end
      if (run_phase == PH_HEADER) begin
        if (char_position >= ADDR_FIRST_POS && char_position <= NAME_LAST_POS &&
            name_char != in_char) begin
          name_differs_next = 1'b1;
        end
      end else if (char_position == '0) begin
        record_kind_next     = (in_char == CH_T) ? REC_T :
                               (in_char == CH_E) ? REC_E : REC_OTHER;
        current_address_next = '0;
        nibble_pending_next  = 1'b0;
        data_ended_next      = 1'b0;
      end else if (record_kind != REC_OTHER) begin
        if (char_position >= ADDR_FIRST_POS && char_position <= ADDR_LAST_POS) begin
          current_address_next = {current_address[ADDR_W-5:0], digit};
          if (record_kind == REC_E && char_position == ADDR_LAST_POS) begin
            run_phase_next = PH_HALT;
            emit           = 1'b1;
            emit_kind      = EV_JUMP;
            emit_addr      = {current_address[ADDR_W-5:0], digit};
          end
        end else if (record_kind == REC_T && char_position >= DATA_START &&
                     !data_ended) begin
          if (nibble_pending) begin
            // second digit of a pair is always taken as a digit, even a separator
            nibble_pending_next  = 1'b0;
            current_address_next = current_address + ADDR_W'(1);
            emit                 = 1'b1;
            emit_kind            = EV_STORE;
            emit_addr            = current_address;
            emit_byte            = {high_nibble, digit};
          end else if (in_char == CH_DOLLAR) begin
            data_ended_next = 1'b1;
          end else if (in_char != CH_CARET) begin
            high_nibble_next    = digit;
            nibble_pending_next = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_name <= '0;
    end else if (cfg_wr_en) begin
      expected_name <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (chars.ready) begin
      in_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.ready && chars.valid) begin
      in_char <= chars.char_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_phase       <= PH_HEADER;
      record_kind     <= REC_OTHER;
      char_position   <= '0;
      current_address <= '0;
      name_differs    <= 1'b0;
      high_nibble     <= '0;
      nibble_pending  <= 1'b0;
      data_ended      <= 1'b0;
    end else if (advance) begin
      run_phase       <= run_phase_next;
      record_kind     <= record_kind_next;
      char_position   <= char_position_next;
      current_address <= current_address_next;
      name_differs    <= name_differs_next;
      high_nibble     <= high_nibble_next;
      nibble_pending  <= nibble_pending_next;
      data_ended      <= data_ended_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (events.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_kind <= emit_kind;
      out_addr <= emit_addr;
      out_byte <= emit_byte;
    end
  end

  assign events.valid        = out_valid;
  assign events.event_kind   = out_kind;
  assign events.load_address = out_addr;
  assign events.load_byte    = out_byte;

  a_halt_quiet: assert property (@(posedge clk) disable iff (rst)
    (run_phase[1] && !events.valid) |=> !events.valid)
    else $error("event produced after halt");

  a_nibble_in_t: assert property (@(posedge clk) disable iff (rst)
    nibble_pending |-> (record_kind == REC_T && run_phase == PH_LOAD))
    else $error("pending nibble outside a T record");

  a_end_in_t: assert property (@(posedge clk) disable iff (rst)
    data_ended |-> (record_kind == REC_T))
    else $error("data end mark outside a T record");

  a_store_incr: assert property (@(posedge clk) disable iff (rst)
    (advance && emit && emit_kind == EV_STORE) |=>
      (current_address == $past(current_address) + ADDR_W'(1)))
    else $error("store address did not advance");

  a_no_emit_in_header: assert property (@(posedge clk) disable iff (rst)
    (run_phase == PH_HEADER && advance && emit) |-> (emit_kind == EV_MISMATCH))
    else $error("data event during header");

endmodule
